// ===== rtl/wbss_pkg.sv =====
`timescale 1ns / 1ps

package wbss_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int SIG_BYTES = 16;
  localparam int SIG_W     = 8 * SIG_BYTES;
  localparam int CARE_W    = 2 * SIG_BYTES;
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NIBBLE_CARE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET    = 8'd4;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== rtl/wbss_cell.sv =====
`timescale 1ns / 1ps

module wbss_cell import wbss_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [7:0]        byte_in,
  input  logic [SIG_W-1:0]  pattern,
  input  logic [CARE_W-1:0] care,
  input  logic [LEN_W-1:0]  eff_len,
  output logic [7:0]        byte_q,
  output logic              hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;
  logic       active;
  logic [6:0] pos_diff;
  logic [3:0] sig_idx;
  logic [7:0] sig_byte;
  logic [7:0] mask;

  // this cell holds the byte that sits len-1-IDX places after the oldest one
  assign active   = {2'b00, eff_len} > 7'(IDX);
  assign pos_diff = {2'b00, eff_len} - 7'd1 - 7'(IDX);
  assign sig_idx  = pos_diff[3:0];
  assign sig_byte = pattern[{sig_idx, 3'b000} +: 8];
  assign mask     = {{4{care[{sig_idx, 1'b1}]}}, {4{care[{sig_idx, 1'b0}]}}};

  // compare against the byte this cell takes on the current shift
  assign hit = !active || (((byte_in ^ sig_byte) & mask) == 8'h00);

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.clear) begin
      byte_nxt = 8'h00;
    end else if (ctrl.shift) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign byte_q = byte_r;

endmodule

// ===== rtl/wildcard_byte_signature_scan.sv =====
`timescale 1ns / 1ps

// Scans a byte stream for a signature of up to 16 bytes in which any nibble can
// be a wildcard. Each input item is one byte (tlast on the final byte of a
// segment); the bytes move through a chain of cells, one per window byte, and
// every cell compares its byte against the signature byte for its place, so all
// start positions are tried and the earliest match is reported. The first match
// gives one result (tuser=1, tdata=base_offset+start position); later bytes of
// the segment are dropped. A segment with no match gives tuser=0, tdata=0 on its
// last byte. The block takes one byte every clock cycle: the shift of the cell
// chain and the compare are done together, and the registered result stage lets
// the next byte in while a result waits; input stalls only while a result is
// held by the downstream side. Configuration: index 0/1 signature bytes 0-7 and
// 8-15, 2 nibble care mask, 3 length (0 reads as 1, above 16 saturates),
// 4 base offset; write only between items.
module wildcard_byte_signature_scan import wbss_pkg::*; #(
  parameter int PATTERN_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // data_byte[7:0]
  input  logic                 in_tlast,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // match_offset[31:0]
  output logic                 out_tuser,  // found
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int CAP = (PATTERN_BYTES < SIG_BYTES) ? PATTERN_BYTES : SIG_BYTES;

  logic [SIG_W-1:0]  pattern_r;
  logic [CARE_W-1:0] care_r;
  logic [LEN_W-1:0]  eff_len_r;
  logic [31:0]       base_r;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic              done_r, done_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [31:0]       offset_r, offset_nxt;

  logic              accept;
  logic              all_hit;
  logic              hit_now;
  logic              result_now;
  logic [LEN_W-1:0]  cfg_len;
  cell_ctrl_t        ctrl;

  logic [7:0]               cell_q   [PATTERN_BYTES];
  logic [7:0]               cell_in  [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] cell_hit;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  assign ctrl.shift = accept && !done_r;
  assign ctrl.clear = accept && in_tlast;

  genvar gi;
  generate
    for (gi = 0; gi < PATTERN_BYTES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign cell_in[gi] = in_tdata;
      end else begin : g_link
        assign cell_in[gi] = cell_q[gi-1];
      end
      wbss_cell #(.IDX(gi)) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .byte_in (cell_in[gi]),
        .pattern (pattern_r),
        .care    (care_r),
        .eff_len (eff_len_r),
        .byte_q  (cell_q[gi]),
        .hit     (cell_hit[gi])
      );
    end
  endgenerate

  assign all_hit    = &cell_hit;
  assign cnt_inc    = (cnt_r == {CNT_W{1'b1}}) ? cnt_r : cnt_r + 32'd1;
  assign hit_now    = ctrl.shift && (cnt_inc >= {27'd0, eff_len_r}) && all_hit;
  assign result_now = hit_now || (ctrl.shift && in_tlast);

  // saturate the length as it is written
  always_comb begin
    cfg_len = cfg_data[LEN_W-1:0];
    if (cfg_len == '0) begin
      cfg_len = LEN_W'(1);
    end else if (cfg_len > LEN_W'(CAP)) begin
      cfg_len = LEN_W'(CAP);
    end
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (ctrl.shift) begin
      cnt_nxt = cnt_inc;
    end
    if (hit_now) begin
      done_nxt      = 1'b1;
      out_valid_nxt = 1'b1;
      found_nxt     = 1'b1;
      offset_nxt    = base_r + cnt_inc - {27'd0, eff_len_r};
    end else if (result_now) begin
      out_valid_nxt = 1'b1;
      found_nxt     = 1'b0;
      offset_nxt    = 32'd0;
    end
    if (ctrl.clear) begin
      cnt_nxt  = '0;
      done_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
      pattern_r   <= '0;
      care_r      <= {CARE_W{1'b1}};
      eff_len_r   <= LEN_W'(1);
      base_r      <= '0;
    end else begin
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_PATTERN_LOW:    pattern_r[63:0]   <= cfg_data;
          CFG_PATTERN_HIGH:   pattern_r[127:64] <= cfg_data;
          CFG_NIBBLE_CARE:    care_r            <= cfg_data[31:0];
          CFG_PATTERN_LENGTH: eff_len_r         <= cfg_len;
          CFG_BASE_OFFSET:    base_r            <= cfg_data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r  <= found_nxt;
    offset_r <= offset_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = offset_r;

  a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> offset_r == 32'd0)
    else $error("not-found item with nonzero offset");

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !result_now)
    else $error("result after a match in the same segment");

  a_hit_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
    hit_now && !in_tlast |=> done_r)
    else $error("match did not mark the segment done");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tlast |=> cnt_r == '0 && !done_r)
    else $error("last byte did not clear the scan");

  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("item taken while a result is held");

endmodule
